### rtl/core/tpwc_pkg.sv
// shared types, constants and helper functions of the teleprinter wheel cipher
`default_nettype none
package tpwc_pkg;

  localparam int WHEEL_COUNT  = 12;
  localparam int CHAR_BITS    = 5;
  localparam int PIN_WORDS    = 8;
  localparam int WORD_BITS    = 64;
  localparam int PATTERN_BITS = PIN_WORDS * WORD_BITS;
  localparam int WINDOW_BITS  = 64;
  localparam int SEL_BITS     = 4;
  localparam int POS_BITS     = 6;
  localparam int REG_IDX_BITS = 4;

  // wheel roles
  localparam int K_COUNT  = 5;
  localparam int WHEEL_M1 = 5;
  localparam int WHEEL_M2 = 6;
  localparam int S_BASE   = 7;

  typedef logic [POS_BITS-1:0]     pos_t;
  typedef logic [SEL_BITS-1:0]     sel_t;
  typedef logic [CHAR_BITS-1:0]    char_t;
  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  typedef enum logic {
    FUNC_ENCIPHER     = 1'b0,
    FUNC_SET_POSITION = 1'b1
  } func_t;

  // first pattern bit of each wheel
  localparam int WHEEL_START [WHEEL_COUNT] = '{
    0, 43, 90, 141, 194, 253, 290, 351, 392, 423, 452, 478
  };

  localparam pos_t WHEEL_LEN [WHEEL_COUNT] = '{
    6'd43, 6'd47, 6'd51, 6'd53, 6'd59, 6'd37, 6'd61,
    6'd41, 6'd31, 6'd29, 6'd26, 6'd23
  };

  // next position with wrap at the wheel length
  function automatic pos_t step_pos(pos_t p, pos_t len);
    return (p == len - 6'd1) ? '0 : p + 6'd1;
  endfunction

  // reduce a 6-bit value modulo a wheel length of at least 23
  function automatic pos_t wrap_pos(pos_t p, pos_t len);
    pos_t r;
    r = p;
    if (r >= len) begin
      r = r - len;
    end
    if (r >= len) begin
      r = r - len;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/tpwc_if.sv
// handshake channel interfaces: input item, result item, register write
`default_nettype none
interface tpwc_in_if;
  logic                 valid;
  logic                 ready;
  tpwc_pkg::func_t      func;
  tpwc_pkg::sel_t       wheel_select;
  tpwc_pkg::pos_t       start_position;
  tpwc_pkg::char_t      char_in;

  modport source (output valid, func, wheel_select, start_position, char_in, input ready);
  modport sink   (input valid, func, wheel_select, start_position, char_in, output ready);
endinterface

interface tpwc_out_if;
  logic            valid;
  logic            ready;
  tpwc_pkg::char_t char_out;

  modport source (output valid, char_out, input ready);
  modport sink   (input valid, char_out, output ready);
endinterface

interface tpwc_cfg_if;
  logic               valid;
  logic               ready;
  tpwc_pkg::reg_idx_t reg_index;
  tpwc_pkg::word_t    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/teleprinter_wheel_cipher_core.sv
// top level of the twelve-wheel teleprinter stream cipher
//
// channel   dir  handshake     payload
// in_ch     in   valid/ready   func, wheel_select, start_position, char_in
// out_ch    out  valid/ready   char_out
// cfg       in   valid/ready   reg_index, data (pin words 0..7)
//
// one item per cycle unless a stalled result holds in_ch: the pin lookup, motor logic and wheel stepping sit
// between the wheel position registers and the result register
// an encipher item gives its result in the cycle after acceptance
// set-position items give no result; selector values above 11 are dropped
// rst (sync, active high) clears positions, pin words and the result valid
// a stalled result only blocks new items when out_ch.ready stays low
// register writes are always accepted; indexes above 7 are ignored
`default_nettype none
module teleprinter_wheel_cipher_core (
  input  wire logic clk,
  input  wire logic rst,
  tpwc_in_if.sink   in_ch,
  tpwc_out_if.source out_ch,
  tpwc_cfg_if.sink  cfg
);

  // pin pattern storage
  tpwc_pkg::word_t pin_word [tpwc_pkg::PIN_WORDS];

  logic [tpwc_pkg::PATTERN_BITS-1:0]                       pattern;
  logic [tpwc_pkg::PATTERN_BITS+tpwc_pkg::WINDOW_BITS-1:0] pattern_ext;

  // wheel state
  tpwc_pkg::pos_t wheel_pos      [tpwc_pkg::WHEEL_COUNT];
  tpwc_pkg::pos_t wheel_pos_next [tpwc_pkg::WHEEL_COUNT];
  tpwc_pkg::pos_t adv_pos        [tpwc_pkg::WHEEL_COUNT];

  logic [tpwc_pkg::WHEEL_COUNT-1:0] pin_cur;
  logic [tpwc_pkg::WHEEL_COUNT-1:0] pin_adv;

  logic            in_fire;
  logic            enc_fire;
  logic            set_fire;
  logic            m1_pin;
  logic            m2_pin;
  logic            s_step;
  tpwc_pkg::char_t key;

  // result register
  logic            out_valid;
  logic            out_valid_next;
  tpwc_pkg::char_t char_out;

  // ---------------------------------------------------------------------
  // register writes
  // ---------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tpwc_pkg::PIN_WORDS; i++) begin
        pin_word[i] <= '0;
      end
    end else if (cfg.valid && (cfg.reg_index < tpwc_pkg::REG_IDX_BITS'(tpwc_pkg::PIN_WORDS))) begin
      pin_word[cfg.reg_index[2:0]] <= cfg.data;
    end
  end

  // flatten the words, pad so every wheel gets a full 64-bit window
  always_comb begin
    for (int i = 0; i < tpwc_pkg::PIN_WORDS; i++) begin
      pattern[i*tpwc_pkg::WORD_BITS +: tpwc_pkg::WORD_BITS] = pin_word[i];
    end
  end

  assign pattern_ext = {{tpwc_pkg::WINDOW_BITS{1'b0}}, pattern};

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  // new item whenever the result register is empty or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign enc_fire    = in_fire && (in_ch.func == tpwc_pkg::FUNC_ENCIPHER);
  assign set_fire    = in_fire && (in_ch.func == tpwc_pkg::FUNC_SET_POSITION);

  // ---------------------------------------------------------------------
  // per-wheel pin readout, at the current and at the advanced position
  // ---------------------------------------------------------------------
  for (genvar w = 0; w < tpwc_pkg::WHEEL_COUNT; w++) begin : g_wheel
    logic [tpwc_pkg::WINDOW_BITS-1:0] window;

    assign window     = pattern_ext[tpwc_pkg::WHEEL_START[w] +: tpwc_pkg::WINDOW_BITS];
    assign adv_pos[w] = tpwc_pkg::step_pos(wheel_pos[w], tpwc_pkg::WHEEL_LEN[w]);
    assign pin_cur[w] = window[wheel_pos[w]];
    assign pin_adv[w] = window[adv_pos[w]];
  end

  // key: bit 4 pairs with chi/psi pair 0
  always_comb begin
    for (int i = 0; i < tpwc_pkg::K_COUNT; i++) begin
      key[tpwc_pkg::K_COUNT-1-i] = pin_cur[i] ^ pin_cur[tpwc_pkg::S_BASE+i];
    end
  end

  // motor logic: m2 follows the new m1 pin, psi wheels follow m1 xor m2
  assign m1_pin = pin_adv[tpwc_pkg::WHEEL_M1];
  assign m2_pin = m1_pin ? pin_adv[tpwc_pkg::WHEEL_M2] : pin_cur[tpwc_pkg::WHEEL_M2];
  assign s_step = m1_pin ^ m2_pin;

  // ---------------------------------------------------------------------
  // wheel position update
  // ---------------------------------------------------------------------
  always_comb begin
    for (int w = 0; w < tpwc_pkg::WHEEL_COUNT; w++) begin
      wheel_pos_next[w] = wheel_pos[w];
      if (set_fire && (in_ch.wheel_select == tpwc_pkg::SEL_BITS'(w))) begin
        wheel_pos_next[w] = tpwc_pkg::wrap_pos(in_ch.start_position, tpwc_pkg::WHEEL_LEN[w]);
      end else if (enc_fire) begin
        if (w < tpwc_pkg::K_COUNT || w == tpwc_pkg::WHEEL_M1) begin
          // chi wheels and m1 always step
          wheel_pos_next[w] = adv_pos[w];
        end else if (w == tpwc_pkg::WHEEL_M2) begin
          if (m1_pin) begin
            wheel_pos_next[w] = adv_pos[w];
          end
        end else if (s_step) begin
          wheel_pos_next[w] = adv_pos[w];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < tpwc_pkg::WHEEL_COUNT; w++) begin
        wheel_pos[w] <= '0;
      end
    end else begin
      for (int w = 0; w < tpwc_pkg::WHEEL_COUNT; w++) begin
        wheel_pos[w] <= wheel_pos_next[w];
      end
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_next = out_valid;
    if (enc_fire) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_fire) begin
      char_out <= in_ch.char_in ^ key;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.char_out = char_out;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  for (genvar w = 0; w < tpwc_pkg::WHEEL_COUNT; w++) begin : g_chk
    a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
      wheel_pos[w] < tpwc_pkg::WHEEL_LEN[w])
      else $error("wheel position beyond wheel length");
  end

  a_enc_gives_result: assert property (@(posedge clk) disable iff (rst)
    enc_fire |=> out_valid)
    else $error("encipher item produced no result");

  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    set_fire |=> !out_valid)
    else $error("set-position item produced a result");

  a_chi_steps: assert property (@(posedge clk) disable iff (rst)
    enc_fire |=> wheel_pos[0] == $past(adv_pos[0]))
    else $error("chi wheel did not step on encipher");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(wheel_pos[tpwc_pkg::WHEEL_M2]) && $stable(wheel_pos[tpwc_pkg::S_BASE]))
    else $error("wheel moved without an item");

endmodule
`default_nettype wire

### tb/tpwc_cipher_checker.sv
// watches the cipher channels, predicts every enciphered character and compares it
`timescale 1ns / 100ps
module tpwc_cipher_checker (
  input  logic        clk,
  input  logic        rst,
  tpwc_in_if          in_ch,
  tpwc_out_if         out_ch,
  tpwc_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned chars_due
);
  import tpwc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  word_t       pin_words [PIN_WORDS];
  pos_t        wheel_at [WHEEL_COUNT];
  char_t       cipher_due [$];
  int unsigned fail_tally = 0;
  int unsigned reported = 0;

  assign fail_count = fail_tally;

  // pin currently under the reader of wheel w
  function automatic logic pin_under(int w);
    int n;
    n = WHEEL_START[w] + int'(wheel_at[w]);
    return pin_words[n / WORD_BITS][n % WORD_BITS];
  endfunction

  function automatic void turn_wheel(int w);
    if (int'(wheel_at[w]) + 1 >= int'(WHEEL_LEN[w])) begin
      wheel_at[w] = '0;
    end else begin
      wheel_at[w] = wheel_at[w] + pos_t'(1);
    end
  endfunction

  // key from chi and psi pins, then the wheel motion of one character
  function automatic char_t encipher_char(char_t plain);
    char_t key;
    key = '0;
    for (int i = 0; i < K_COUNT; i++) begin
      key[CHAR_BITS-1-i] = pin_under(i) ^ pin_under(S_BASE + i);
    end
    for (int i = 0; i < K_COUNT; i++) begin
      turn_wheel(i);
    end
    turn_wheel(WHEEL_M1);
    if (pin_under(WHEEL_M1)) begin
      turn_wheel(WHEEL_M2);
    end
    if (pin_under(WHEEL_M1) ^ pin_under(WHEEL_M2)) begin
      for (int i = S_BASE; i < WHEEL_COUNT; i++) begin
        turn_wheel(i);
      end
    end
    return plain ^ key;
  endfunction

  always @(posedge clk) begin
    char_t want;
    if (rst) begin
      for (int i = 0; i < PIN_WORDS; i++) begin
        pin_words[i] = '0;
      end
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        wheel_at[i] = '0;
      end
      cipher_due.delete();
    end else begin
      // results first: an item accepted at this edge cannot be answered at it
      if (out_ch.valid && out_ch.ready) begin
        if (cipher_due.size() == 0) begin
          fail_tally++;
          if (reported < REPORT_LIMIT) begin
            $display("%0t: result %h with no character pending", $time, out_ch.char_out);
            reported++;
          end
        end else begin
          want = cipher_due.pop_front();
          if (out_ch.char_out !== want) begin
            fail_tally++;
            if (reported < REPORT_LIMIT) begin
              $display("%0t: char_out expected %h got %h", $time, want, out_ch.char_out);
              reported++;
            end
          end
        end
      end
      if (cfg.valid && cfg.ready && cfg.reg_index < PIN_WORDS) begin
        pin_words[cfg.reg_index[2:0]] = cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_ENCIPHER) begin
          cipher_due.push_back(encipher_char(in_ch.char_in));
        end else if (in_ch.wheel_select < WHEEL_COUNT) begin
          wheel_at[in_ch.wheel_select] =
            pos_t'(in_ch.start_position % WHEEL_LEN[in_ch.wheel_select]);
        end
      end
    end
    chars_due <= cipher_due.size();
  end

endmodule

### tb/tb_teleprinter_wheel_cipher_core.sv
// testbench top: clock, reset, item stimulus, result pacing and the verdict
`timescale 1ns / 100ps
module tb_teleprinter_wheel_cipher_core;
  import tpwc_pkg::*;

  localparam int       WATCHDOG_CYCLES  = 2000;
  localparam int       MAX_GAP          = 17;
  localparam int       LONG_HOLD_AT     = 300;
  localparam int       LONG_HOLD_CYCLES = 160;
  localparam int       DRAIN_CYCLES     = 6;
  localparam int       RANDOM_ITEMS     = 1880;
  localparam int       PHASES           = 8;
  localparam reg_idx_t REG_UNUSED_LO    = 4'd8;
  localparam reg_idx_t REG_UNUSED_HI    = 4'd15;
  localparam sel_t     SEL_UNUSED_LO    = 4'd12;
  localparam sel_t     SEL_UNUSED_HI    = 4'd15;
  localparam pos_t     POS_MAX          = '1;
  localparam pos_t     POS_RANGE_TOP    = 6'd60;

  // fill patterns for the pin words
  typedef enum int {
    PINS_CLEAR,
    PINS_SET,
    PINS_ODD,
    PINS_EVEN,
    PINS_RANDOM
  } pin_fill_e;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned chars_due;
  int unsigned idle_cycles = 0;
  int unsigned results_taken = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_gaps = 1'b0;

  tpwc_in_if  in_ch ();
  tpwc_out_if out_ch ();
  tpwc_cfg_if cfg_ch ();

  teleprinter_wheel_cipher_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  tpwc_cipher_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .chars_due  (chars_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // idle cycles before the next item on one side, none when that side runs flat out
  function automatic int unsigned draw_gap(bit enabled);
    return enabled ? $urandom_range(MAX_GAP, 0) : 0;
  endfunction

  // valid stays high from one item to the next when no gap is drawn
  task automatic offer_item(func_t f, sel_t sel, pos_t pos, char_t ch);
    int unsigned gap;
    gap = draw_gap(tx_gaps);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= f;
    in_ch.wheel_select   <= sel;
    in_ch.start_position <= pos;
    in_ch.char_in        <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // selector and position ride along with random bits, the block ignores them
  task automatic encipher(char_t ch);
    offer_item(FUNC_ENCIPHER, sel_t'($urandom), pos_t'($urandom), ch);
  endtask

  // char_in rides along with random bits here
  task automatic set_wheel(sel_t sel, pos_t pos);
    offer_item(FUNC_SET_POSITION, sel, pos, char_t'($urandom));
  endtask

  task automatic write_reg(reg_idx_t idx, word_t value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // all eight pin words, then one write to an index past the last word
  task automatic load_pattern(pin_fill_e fill, reg_idx_t unused_idx);
    word_t w;
    for (int i = 0; i < PIN_WORDS; i++) begin
      case (fill)
        PINS_CLEAR: w = '0;
        PINS_SET:   w = '1;
        PINS_ODD:   w = {32{2'b01}};
        PINS_EVEN:  w = {32{2'b10}};
        default:    w = {$urandom, $urandom};
      endcase
      write_reg(reg_idx_t'(i), w);
    end
    write_reg(unused_idx, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering and wait for every pending character, plus slack for
  // set-position items still on their way through
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random step: mostly single items, sometimes a full key setting followed
  // by a run of characters as a real message would look
  task automatic random_step(output int unsigned counted);
    int unsigned pick;
    int unsigned run;
    pick    = $urandom_range(99, 0);
    counted = 1;
    if (pick < 8) begin
      for (int w = 0; w < WHEEL_COUNT; w++) begin
        set_wheel(sel_t'(w), pos_t'($urandom));
      end
      run = $urandom_range(30, 5);
      for (int i = 0; i < run; i++) begin
        encipher(char_t'($urandom));
      end
      counted = WHEEL_COUNT + run;
    end else if (pick < 72) begin
      encipher(char_t'($urandom));
    end else if (pick < 96) begin
      set_wheel(sel_t'($urandom_range(WHEEL_COUNT - 1, 0)), pos_t'($urandom));
    end else begin
      // selector beyond the last wheel: dropped, so it does not count
      set_wheel(sel_t'($urandom_range(SEL_UNUSED_HI, SEL_UNUSED_LO)), pos_t'($urandom));
      counted = 0;
    end
  endtask

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned counted;
    pin_fill_e   fill;
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.func           <= FUNC_ENCIPHER;
    in_ch.wheel_select   <= '0;
    in_ch.start_position <= '0;
    in_ch.char_in        <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reg_index     <= '0;
    cfg_ch.data          <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pins are clear after reset, so characters pass through unchanged
    encipher('1);
    encipher('0);
    drain();

    load_pattern(PINS_RANDOM, REG_UNUSED_HI);
    // every wheel loaded: past the length by far, the last pin, exactly the length
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      case (w % 3)
        0:       set_wheel(sel_t'(w), POS_MAX);
        1:       set_wheel(sel_t'(w), pos_t'(WHEEL_LEN[w] - 1));
        default: set_wheel(sel_t'(w), WHEEL_LEN[w]);
      endcase
    end
    encipher(5'h1f);
    encipher(5'h00);
    encipher(5'h15);
    encipher(5'h0a);
    // selectors past the last wheel leave every position alone
    set_wheel(SEL_UNUSED_LO, '0);
    set_wheel(SEL_UNUSED_HI, '0);
    encipher(5'h11);
    // motor wheels at the top of the position range and at zero
    set_wheel(sel_t'(WHEEL_M1), '0);
    set_wheel(sel_t'(WHEEL_M2), POS_RANGE_TOP);
    encipher(5'h0e);
    encipher(5'h1b);
    drain();

    // random part, a fresh pin pattern and idling mix per phase
    sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       fill = PINS_SET;
        2:       fill = PINS_CLEAR;
        3:       fill = PINS_ODD;
        4:       fill = PINS_EVEN;
        default: fill = PINS_RANDOM;
      endcase
      // phase 1 runs both sides flat out, others mix gaps in
      tx_gaps = (phase % 3) != 1;
      rx_gaps = (phase % 4) != 1;
      load_pattern(fill, reg_idx_t'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)));
      while (sent < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        random_step(counted);
        sent += counted;
      end
      drain();
    end

    if (fail_count == 0 && chars_due == 0) begin
      $display("[teleprinter_wheel_cipher_core] OK");
    end else begin
      $display("[teleprinter_wheel_cipher_core] ERROR");
    end
    $finish;
  end

  // result side: random stalls per item, and one long hold-off so the block
  // backs up into its input while the sender keeps offering
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (results_taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(rx_gaps);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_taken++;
    end
  end

  // watchdog: too long without any accepted item on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
      $display("[teleprinter_wheel_cipher_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
